// File: rtl/gbnsw_pkg.sv
// ----------------------------------------------------------------------------
// gbnsw_pkg
// Shared types and constants for the go-back-N send window.
// ----------------------------------------------------------------------------
package gbnsw_pkg;

   localparam int WINDOW_DEPTH_DEF = 16;
   localparam int SEQ_W            = 32;
   localparam int DATA_W           = 32;
   localparam int LIMIT_W          = 5;
   localparam int COUNT_OUT_W      = 5;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 3;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // register index, taken from paddr[2]
   localparam logic CSR_WINDOW_LIMIT = 1'b0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DROP_RD,
      ST_DROP_CMP,
      ST_DROP_FIX,
      ST_ACK_SEQ,
      ST_TAIL_RD,
      ST_TAIL_CMP,
      ST_APPEND,
      ST_ACK_UPD,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_DONE
   } gbnsw_state_type;

endpackage

// File: rtl/gbnsw_entry_ram.sv
// ----------------------------------------------------------------------------
// gbnsw_entry_ram
// Window entry store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gbnsw_entry_ram #(
   parameter int DEPTH  = gbnsw_pkg::WINDOW_DEPTH_DEF,
   parameter int IDX_W  = 4,
   parameter int WORD_W = 64
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/go_back_n_send_window.sv
// ----------------------------------------------------------------------------
// go_back_n_send_window
// Sender side of a go-back-N window: ring of unacked entries, ack tracking
// and lookup of the next entry to retransmit.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per sent message (seq, data, optional cumulative
//   ack). rsp_* returns one result item per request: occupancy, full flag,
//   drop flag, ack status and the entry to resend. Both channels are
//   valid/ready. window_limit is written over the csr_ APB port at offset 0.
// Structure:
//   One 32-bit comparator and one ring-address adder are shared by a
//   sequencer that walks the entry RAM, reading each entry visited and
//   then comparing it. The walk covers the entries dropped by the ack
//   and the entries compared in the resend search. req_ready is high
//   only in idle, so a new item is not accepted until the previous one
//   has been moved into the output register.
// Reset clears the count, ack state and limit (16); entry RAM is not
// cleared, only entries below the count are read. A stalled result holds
// in the output register while the next item is already accepted.
// ----------------------------------------------------------------------------
module go_back_n_send_window #(
   parameter int WINDOW_DEPTH = gbnsw_pkg::WINDOW_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [gbnsw_pkg::SEQ_W-1:0]         req_msg_seq,
   input  logic [gbnsw_pkg::DATA_W-1:0]        req_msg_data,
   input  logic                                req_ack_valid,
   input  logic [gbnsw_pkg::SEQ_W-1:0]         req_ack_seq,
   // response
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [gbnsw_pkg::COUNT_OUT_W-1:0]   rsp_window_count,
   output logic                                rsp_window_full,
   output logic                                rsp_append_dropped,
   output logic                                rsp_ack_seen,
   output logic [gbnsw_pkg::SEQ_W-1:0]         rsp_highest_ack,
   output logic                                rsp_resend_found,
   output logic [gbnsw_pkg::SEQ_W-1:0]         rsp_resend_seq,
   output logic [gbnsw_pkg::DATA_W-1:0]        rsp_resend_data,
   // configuration
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gbnsw_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [gbnsw_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [gbnsw_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   import gbnsw_pkg::*;

   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W  = CNT_W + 1;
   localparam int LIM_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam int WORD_W = SEQ_W + DATA_W;

   gbnsw_state_type state_ff, state_in;

   logic [IDX_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   walk_ff, walk_in;
   logic [SEQ_W-1:0]   seq_ff, seq_in;
   logic [DATA_W-1:0]  data_ff, data_in;
   logic               ackv_ff, ackv_in;
   logic [SEQ_W-1:0]   ack_ff, ack_in;
   logic               want_ff, want_in;
   logic               dropped_ff, dropped_in;
   logic [SEQ_W-1:0]   last_ack_ff, last_ack_in;
   logic               seen_ff, seen_in;
   logic               found_ff, found_in;
   logic [SEQ_W-1:0]   rs_seq_ff, rs_seq_in;
   logic [DATA_W-1:0]  rs_data_ff, rs_data_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_OUT_W-1:0] out_count_ff, out_count_in;
   logic                   out_full_ff, out_full_in;
   logic                   out_dropped_ff, out_dropped_in;
   logic                   out_seen_ff, out_seen_in;
   logic [SEQ_W-1:0]       out_ack_ff, out_ack_in;
   logic                   out_found_ff, out_found_in;
   logic [SEQ_W-1:0]       out_rseq_ff, out_rseq_in;
   logic [DATA_W-1:0]      out_rdata_ff, out_rdata_in;

   logic [LIM_W-1:0]   lim_ext, eff_lim;
   logic               room;
   logic [CNT_W-1:0]   addr_off;
   logic [SUM_W-1:0]   addr_sum, addr_wrap;
   logic [IDX_W-1:0]   ring_addr;
   logic [SEQ_W-1:0]   cmp_a, cmp_b;
   logic               cmp_lt, cmp_eq;
   logic [SEQ_W-1:0]   target;
   logic               ram_wr_en;
   logic [WORD_W-1:0]  ram_rd_data;
   logic [SEQ_W-1:0]   rd_seq;
   logic [DATA_W-1:0]  rd_data;
   logic               csr_write;

   gbnsw_entry_ram #(
      .DEPTH  (WINDOW_DEPTH),
      .IDX_W  (IDX_W),
      .WORD_W (WORD_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ring_addr),
      .wr_data ({seq_ff, data_ff}),
      .rd_addr (ring_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_seq  = ram_rd_data[WORD_W-1:DATA_W];
   assign rd_data = ram_rd_data[DATA_W-1:0];

   // limit of 0 acts as 1, above depth acts as depth
   always_comb begin
      lim_ext = LIM_W'(limit_ff);
      if (limit_ff == '0) begin
         eff_lim = LIM_W'(1);
      end else if (lim_ext > LIM_W'(WINDOW_DEPTH)) begin
         eff_lim = LIM_W'(WINDOW_DEPTH);
      end else begin
         eff_lim = lim_ext;
      end
   end

   assign room = LIM_W'(count_ff) < eff_lim;

   // ring address adder: head plus an offset, wrapped at the depth
   always_comb begin
      unique case (state_ff)
         ST_TAIL_RD: addr_off = CNT_W'(count_ff - 1'b1);
         ST_APPEND:  addr_off = count_ff;
         default:    addr_off = walk_ff;
      endcase
      addr_sum  = SUM_W'(head_ff) + SUM_W'(addr_off);
      addr_wrap = (addr_sum >= SUM_W'(WINDOW_DEPTH)) ?
                  SUM_W'(addr_sum - SUM_W'(WINDOW_DEPTH)) : addr_sum;
      ring_addr = addr_wrap[IDX_W-1:0];
   end

   assign target = seen_ff ? SEQ_W'(last_ack_ff + 1'b1) : '0;

   // shared comparator
   always_comb begin
      unique case (state_ff)
         ST_DROP_CMP: begin
            cmp_a = ack_ff;
            cmp_b = rd_seq;
         end
         ST_ACK_SEQ: begin
            cmp_a = ack_ff;
            cmp_b = seq_ff;
         end
         ST_TAIL_CMP: begin
            cmp_a = rd_seq;
            cmp_b = seq_ff;
         end
         ST_ACK_UPD: begin
            cmp_a = last_ack_ff;
            cmp_b = ack_ff;
         end
         ST_SRCH_CMP: begin
            cmp_a = rd_seq;
            cmp_b = target;
         end
         default: begin
            cmp_a = ack_ff;
            cmp_b = seq_ff;
         end
      endcase
      cmp_lt = cmp_a < cmp_b;
      cmp_eq = cmp_a == cmp_b;
   end

   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      state_in       = state_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      walk_in        = walk_ff;
      seq_in         = seq_ff;
      data_in        = data_ff;
      ackv_in        = ackv_ff;
      ack_in         = ack_ff;
      want_in        = want_ff;
      dropped_in     = dropped_ff;
      last_ack_in    = last_ack_ff;
      seen_in        = seen_ff;
      found_in       = found_ff;
      rs_seq_in      = rs_seq_ff;
      rs_data_in     = rs_data_ff;
      limit_in       = limit_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      out_count_in   = out_count_ff;
      out_full_in    = out_full_ff;
      out_dropped_in = out_dropped_ff;
      out_seen_in    = out_seen_ff;
      out_ack_in     = out_ack_ff;
      out_found_in   = out_found_ff;
      out_rseq_in    = out_rseq_ff;
      out_rdata_in   = out_rdata_ff;
      ram_wr_en      = 1'b0;
      req_ready      = 1'b0;

      if (csr_write && csr_paddr[2] == CSR_WINDOW_LIMIT) begin
         limit_in = csr_pwdata[LIMIT_W-1:0];
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               seq_in     = req_msg_seq;
               data_in    = req_msg_data;
               ackv_in    = req_ack_valid;
               ack_in     = req_ack_seq;
               walk_in    = '0;
               want_in    = 1'b1;
               dropped_in = 1'b0;
               found_in   = 1'b0;
               rs_seq_in  = '0;
               rs_data_in = '0;
               state_in   = req_ack_valid ? ST_DROP_RD : ST_TAIL_RD;
            end
         end
         ST_DROP_RD: begin
            state_in = (walk_ff == count_ff) ? ST_DROP_FIX : ST_DROP_CMP;
         end
         ST_DROP_CMP: begin
            // entry at or below the ack: drop it and look at the next
            if (!cmp_lt) begin
               walk_in  = CNT_W'(walk_ff + 1'b1);
               state_in = ST_DROP_RD;
            end else begin
               state_in = ST_DROP_FIX;
            end
         end
         ST_DROP_FIX: begin
            head_in  = ring_addr;
            count_in = CNT_W'(count_ff - walk_ff);
            state_in = ST_ACK_SEQ;
         end
         ST_ACK_SEQ: begin
            want_in  = cmp_lt;
            state_in = ST_TAIL_RD;
         end
         ST_TAIL_RD: begin
            state_in = (count_ff == '0) ? ST_APPEND : ST_TAIL_CMP;
         end
         ST_TAIL_CMP: begin
            want_in  = want_ff & cmp_lt;
            state_in = ST_APPEND;
         end
         ST_APPEND: begin
            if (want_ff) begin
               if (room) begin
                  ram_wr_en = 1'b1;
                  count_in  = CNT_W'(count_ff + 1'b1);
               end else begin
                  dropped_in = 1'b1;
               end
            end
            walk_in  = '0;
            state_in = ackv_ff ? ST_ACK_UPD : ST_SRCH_RD;
         end
         ST_ACK_UPD: begin
            if (!seen_ff || cmp_lt) begin
               last_ack_in = ack_ff;
               seen_in     = 1'b1;
            end
            state_in = ST_SRCH_RD;
         end
         ST_SRCH_RD: begin
            state_in = (walk_ff == count_ff) ? ST_DONE : ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (cmp_eq) begin
               found_in   = 1'b1;
               rs_seq_in  = rd_seq;
               rs_data_in = rd_data;
               state_in   = ST_DONE;
            end else begin
               walk_in  = CNT_W'(walk_ff + 1'b1);
               state_in = ST_SRCH_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in   = 1'b1;
               out_count_in   = COUNT_OUT_W'(count_ff);
               out_full_in    = ~room;
               out_dropped_in = dropped_ff;
               out_seen_in    = seen_ff;
               out_ack_in     = last_ack_ff;
               out_found_in   = found_ff;
               out_rseq_in    = rs_seq_ff;
               out_rdata_in   = rs_data_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         last_ack_ff  <= '0;
         seen_ff      <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         last_ack_ff  <= last_ack_in;
         seen_ff      <= seen_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff        <= walk_in;
      seq_ff         <= seq_in;
      data_ff        <= data_in;
      ackv_ff        <= ackv_in;
      ack_ff         <= ack_in;
      want_ff        <= want_in;
      dropped_ff     <= dropped_in;
      found_ff       <= found_in;
      rs_seq_ff      <= rs_seq_in;
      rs_data_ff     <= rs_data_in;
      out_count_ff   <= out_count_in;
      out_full_ff    <= out_full_in;
      out_dropped_ff <= out_dropped_in;
      out_seen_ff    <= out_seen_in;
      out_ack_ff     <= out_ack_in;
      out_found_ff   <= out_found_in;
      out_rseq_ff    <= out_rseq_in;
      out_rdata_ff   <= out_rdata_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_window_count   = out_count_ff;
   assign rsp_window_full    = out_full_ff;
   assign rsp_append_dropped = out_dropped_ff;
   assign rsp_ack_seen       = out_seen_ff;
   assign rsp_highest_ack    = out_ack_ff;
   assign rsp_resend_found   = out_found_ff;
   assign rsp_resend_seq     = out_rseq_ff;
   assign rsp_resend_data    = out_rdata_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_WINDOW_LIMIT) ?
                       CSR_DATA_W'(limit_ff) : '0;

endmodule
